[hdl/circle_canvas_rasterizer_macros.svh]
// Assertion macros for the rasterizer RTL, used by the controller.
// CCR_ASSERT_CLK names its clock and reset; CCR_ASSERT uses clk and arst_n.
`ifndef CIRCLE_CANVAS_RASTERIZER_MACROS_SVH
`define CIRCLE_CANVAS_RASTERIZER_MACROS_SVH
`ifndef SYNTHESIS
`define CCR_ASSERT_CLK(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define CCR_ASSERT(lbl, prop, msg) \
	`CCR_ASSERT_CLK(lbl, clk, arst_n, prop, msg)
`else
`define CCR_ASSERT_CLK(lbl, ck, rn, prop, msg)
`define CCR_ASSERT(lbl, prop, msg)
`endif
`endif

[hdl/ccr_pkg.sv]
`default_nettype none
package ccr_pkg;

	// Canvas geometry and fixed-point format
	localparam int MAX_COLUMNS   = 512;
	localparam int MAX_ROWS      = 512;
	localparam int FRACTION_BITS = 8;

	// Fixed field widths
	localparam int COORD_W   = 20;
	localparam int RADIUS_W  = 20;
	localparam int BYTE_W    = 8;
	localparam int PIXIDX_W  = 9;
	localparam int CFG_DIM_W = 10;
	localparam int CFG_IDX_W = 2;

	// Derived widths
	localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COLN_W = $clog2(MAX_COLUMNS + 1);
	localparam int ROWN_W = $clog2(MAX_ROWS + 1);
	localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + FRACTION_BITS;
	localparam int DX_W   = ((POS_W > COORD_W) ? POS_W : COORD_W) + 1;
	localparam int SQ_W   = 2 * DX_W;
	localparam int D2_W   = SQ_W + 1;
	localparam int R2_W   = 2 * RADIUS_W;

	typedef enum logic [1:0] {
		ACT_DRAW  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_BG     = 2'd2
	} reg_idx_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic capture;
	} ccr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic rd_outside;
		logic last_pixel;
		logic pipe_busy;
	} ccr_stat_t;

endpackage
`default_nettype wire

[hdl/ccr_ram.sv]
`default_nettype none
module ccr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read first port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

[hdl/ccr_ctrl.sv]
`default_nettype none
`include "circle_canvas_rasterizer_macros.svh"
module ccr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         action,
	input  wire ccr_pkg::ccr_stat_t stat,
	output ccr_pkg::ccr_cmd_t       cmd,
	output logic                    busy,
	output logic                    done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RD_ADDR,
		ST_RD_DATA
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;

	// Drive datapath commands
	always_comb begin
		cmd.load    = accept;
		cmd.step    = (state_q == ST_SCAN);
		cmd.capture = (state_q == ST_RD_DATA);
	end

	// Sequence one word at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (ccr_pkg::action_t'(action))
							ccr_pkg::ACT_DRAW, ccr_pkg::ACT_CLEAR: begin
								if (stat.empty) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							ccr_pkg::ACT_READ: begin
								if (stat.rd_outside) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_RD_ADDR;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (stat.last_pixel) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CCR_ASSERT(a_done_idle, done_q |-> (state_q == ST_IDLE), "result strobe while busy")
	`CCR_ASSERT(a_read_port_free, (state_q == ST_RD_ADDR) |-> !stat.pipe_busy, "read during write")
	`CCR_ASSERT(a_drain_done, (state_q == ST_DRAIN) && !stat.pipe_busy |=> done_q, "lost draw result")

endmodule
`default_nettype wire

[hdl/ccr_datapath.sv]
`default_nettype none
module ccr_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ccr_pkg::ccr_cmd_t                  cmd,
	output ccr_pkg::ccr_stat_t                      stat,
	input  wire logic                               cfg_we,
	input  wire logic [ccr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ccr_pkg::CFG_DIM_W-1:0]      cfg_data,
	input  wire logic [1:0]                         action,
	input  wire logic                               outline_only,
	input  wire logic signed [ccr_pkg::COORD_W-1:0] center_x,
	input  wire logic signed [ccr_pkg::COORD_W-1:0] center_y,
	input  wire logic [ccr_pkg::RADIUS_W-1:0]       radius,
	input  wire logic [ccr_pkg::BYTE_W-1:0]         paint_byte,
	input  wire logic [ccr_pkg::PIXIDX_W-1:0]       pixel_col,
	input  wire logic [ccr_pkg::PIXIDX_W-1:0]       pixel_row,
	output logic [ccr_pkg::BYTE_W-1:0]              pixel_value,
	output logic                                    outside_canvas
);

	localparam int COL_W  = ccr_pkg::COL_W;
	localparam int ROW_W  = ccr_pkg::ROW_W;
	localparam int COLN_W = ccr_pkg::COLN_W;
	localparam int ROWN_W = ccr_pkg::ROWN_W;
	localparam int ADDR_W = ccr_pkg::ADDR_W;
	localparam int DX_W   = ccr_pkg::DX_W;
	localparam int SQ_W   = ccr_pkg::SQ_W;
	localparam int D2_W   = ccr_pkg::D2_W;
	localparam int R2_W   = ccr_pkg::R2_W;
	localparam int R_W    = ccr_pkg::RADIUS_W;
	localparam int B_W    = ccr_pkg::BYTE_W;
	localparam int FB     = ccr_pkg::FRACTION_BITS;

	// Configuration registers
	logic [ccr_pkg::CFG_DIM_W-1:0] width_q, height_q;
	logic [B_W-1:0]                bg_q;

	// Latched item
	logic                          outline_q, clear_q;
	logic signed [ccr_pkg::COORD_W-1:0] cx_q, cy_q;
	logic [R_W-1:0]                radius_q;
	logic [B_W-1:0]                paint_q;
	logic [ADDR_W-1:0]             rd_addr_q;

	// Radius squares
	logic [R2_W-1:0]               r2_q, m2_q;
	logic                          m_neg_q;
	logic [R_W:0]                  m_full;

	// Scan counters
	logic [COL_W-1:0]              col_q;
	logic [ROW_W-1:0]              row_q;
	logic [COLN_W-1:0]             used_cols;
	logic [ROWN_W-1:0]             used_rows;
	logic                          col_last, row_last;

	// Pixel pipeline
	logic                          vld_s1, vld_s2, vld_s3, we_s4;
	logic signed [DX_W-1:0]        dx_s1, dy_s1;
	logic [ADDR_W-1:0]             addr_s1, addr_s2, addr_s3, addr_s4;
	logic [SQ_W-1:0]               dx2_s2, dy2_s2;
	logic [D2_W-1:0]               d2_s3;
	logic signed [SQ_W-1:0]        dx_sq, dy_sq;
	logic                          hit;

	// Memory port
	logic [ADDR_W-1:0]             ram_addr;
	logic [B_W-1:0]                ram_wdata, ram_rdata;

	// Saturate canvas size to the store dimensions
	assign used_cols = (32'(width_q) > ccr_pkg::MAX_COLUMNS) ?
		COLN_W'(ccr_pkg::MAX_COLUMNS) : COLN_W'(width_q);
	assign used_rows = (32'(height_q) > ccr_pkg::MAX_ROWS) ?
		ROWN_W'(ccr_pkg::MAX_ROWS) : ROWN_W'(height_q);

	assign col_last = (COLN_W'(col_q) == used_cols - COLN_W'(1));
	assign row_last = (ROWN_W'(row_q) == used_rows - ROWN_W'(1));

	always_comb begin
		stat.empty      = (used_cols == '0) || (used_rows == '0);
		stat.rd_outside = (32'(pixel_col) >= 32'(used_cols)) ||
		                  (32'(pixel_row) >= 32'(used_rows));
		stat.last_pixel = col_last && row_last;
		stat.pipe_busy  = vld_s1 || vld_s2 || vld_s3 || we_s4;
	end

	// Take configuration words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ccr_pkg::CFG_DIM_W'(512);
			height_q <= ccr_pkg::CFG_DIM_W'(512);
			bg_q     <= B_W'(32);
		end else if (cfg_we) begin
			case (ccr_pkg::reg_idx_t'(cfg_index))
				ccr_pkg::REG_WIDTH:  width_q  <= cfg_data;
				ccr_pkg::REG_HEIGHT: height_q <= cfg_data;
				ccr_pkg::REG_BG:     bg_q     <= cfg_data[B_W-1:0];
				default: ;
			endcase
		end
	end

	// Latch item fields on accept
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			outline_q <= outline_only;
			clear_q   <= (action == ccr_pkg::ACT_CLEAR);
			cx_q      <= center_x;
			cy_q      <= center_y;
			radius_q  <= radius;
			paint_q   <= paint_byte;
			rd_addr_q <= ADDR_W'(pixel_row) * ADDR_W'(ccr_pkg::MAX_COLUMNS) +
			             ADDR_W'(pixel_col);
		end
	end

	// Square the radius and the radius less one pixel
	assign m_full = {1'b0, radius_q} - (R_W+1)'(1 << FB);

	always_ff @(posedge clk) begin
		r2_q    <= R2_W'(radius_q) * R2_W'(radius_q);
		m_neg_q <= m_full[R_W];
		m2_q    <= R2_W'(m_full[R_W-1:0]) * R2_W'(m_full[R_W-1:0]);
	end

	// Advance the scan raster
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.step) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			we_s4  <= 1'b0;
		end else begin
			vld_s1 <= cmd.step;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			we_s4  <= vld_s3 && (clear_q || hit);
		end
	end

	assign dx_sq = SQ_W'(dx_s1) * SQ_W'(dx_s1);
	assign dy_sq = SQ_W'(dy_s1) * SQ_W'(dy_s1);

	// Ring drops pixels within radius minus one
	assign hit = (d2_s3 <= D2_W'(r2_q)) &&
	             !(outline_q && !m_neg_q && (d2_s3 <= D2_W'(m2_q)));

	// Offsets, squares, sum, test
	always_ff @(posedge clk) begin
		dx_s1   <= DX_W'(cx_q) - (DX_W'(col_q) << FB);
		dy_s1   <= DX_W'(cy_q) - (DX_W'(row_q) << FB);
		addr_s1 <= ADDR_W'(row_q) * ADDR_W'(ccr_pkg::MAX_COLUMNS) + ADDR_W'(col_q);
		dx2_s2  <= unsigned'(dx_sq);
		dy2_s2  <= unsigned'(dy_sq);
		addr_s2 <= addr_s1;
		d2_s3   <= D2_W'(dx2_s2) + D2_W'(dy2_s2);
		addr_s3 <= addr_s2;
		addr_s4 <= addr_s3;
	end

	assign ram_addr  = we_s4 ? addr_s4 : rd_addr_q;
	assign ram_wdata = clear_q ? bg_q : paint_q;

	ccr_ram #(
		.WIDTH (B_W),
		.DEPTH (ccr_pkg::DEPTH)
	) u_canvas (
		.clk   (clk),
		.we    (we_s4),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Hold result word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pixel_value    <= '0;
			outside_canvas <= (action == ccr_pkg::ACT_READ) && stat.rd_outside;
		end else if (cmd.capture) begin
			pixel_value <= ram_rdata;
		end
	end

endmodule
`default_nettype wire

[hdl/circle_canvas_rasterizer.sv]
// Channel   Handshake               Payload
// item      start / busy            action outline_only center_x center_y radius
//                                   paint_byte pixel_col pixel_row
// result    done (one-cycle strobe) pixel_value outside_canvas
// config    cfg_valid / cfg_ready   cfg_index cfg_data
//
// An item is taken when start is high and busy low; busy stays high until its result.
// Draw and clear scan the canvas in use at one pixel per cycle through the canvas RAM
// write port, then wait for the pipeline to drain. A read passes through an address
// state and a data state to its strobe; an empty canvas, a read outside it or an
// unused action strobes in the cycle after the item. The canvas RAM is not cleared at
// reset; configuration resets to 512 x 512 and background 32. cfg_ready is always high.
`default_nettype none
module circle_canvas_rasterizer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         action,
	input  wire logic                               outline_only,
	input  wire logic signed [ccr_pkg::COORD_W-1:0] center_x,
	input  wire logic signed [ccr_pkg::COORD_W-1:0] center_y,
	input  wire logic [ccr_pkg::RADIUS_W-1:0]       radius,
	input  wire logic [ccr_pkg::BYTE_W-1:0]         paint_byte,
	input  wire logic [ccr_pkg::PIXIDX_W-1:0]       pixel_col,
	input  wire logic [ccr_pkg::PIXIDX_W-1:0]       pixel_row,
	output logic                                    done,
	output logic [ccr_pkg::BYTE_W-1:0]              pixel_value,
	output logic                                    outside_canvas,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ccr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ccr_pkg::CFG_DIM_W-1:0]      cfg_data
);

	ccr_pkg::ccr_cmd_t  cmd;
	ccr_pkg::ccr_stat_t stat;

	assign cfg_ready = 1'b1;

	ccr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ccr_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.action         (action),
		.outline_only   (outline_only),
		.center_x       (center_x),
		.center_y       (center_y),
		.radius         (radius),
		.paint_byte     (paint_byte),
		.pixel_col      (pixel_col),
		.pixel_row      (pixel_row),
		.pixel_value    (pixel_value),
		.outside_canvas (outside_canvas)
	);

endmodule
`default_nettype wire

[bench/tb_circle_canvas_rasterizer.sv]
`timescale 1ns / 100ps
module tb_circle_canvas_rasterizer;

	localparam logic [1:0]                    ACT_UNUSED = 2'd3;
	localparam logic [ccr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int                            NUM_RANDOM = 74;

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                          kind;
		logic [1:0]                         act;
		logic                               outl;
		logic signed [ccr_pkg::COORD_W-1:0] cx;
		logic signed [ccr_pkg::COORD_W-1:0] cy;
		logic [ccr_pkg::RADIUS_W-1:0]       rad;
		logic [ccr_pkg::BYTE_W-1:0]         paint;
		logic [ccr_pkg::PIXIDX_W-1:0]       pcol;
		logic [ccr_pkg::PIXIDX_W-1:0]       prow;
		logic [ccr_pkg::CFG_IDX_W-1:0]      reg_idx;
		logic [ccr_pkg::CFG_DIM_W-1:0]      reg_data;
		bit                                 golden;
		logic [ccr_pkg::BYTE_W-1:0]         gold_value;
		logic                               gold_outside;
	} word_row_t;

	typedef struct packed {
		logic [ccr_pkg::BYTE_W-1:0] value;
		logic                       outside;
	} pixel_word_t;

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [1:0]                         action;
	logic                               outline_only;
	logic signed [ccr_pkg::COORD_W-1:0] center_x;
	logic signed [ccr_pkg::COORD_W-1:0] center_y;
	logic [ccr_pkg::RADIUS_W-1:0]       radius;
	logic [ccr_pkg::BYTE_W-1:0]         paint_byte;
	logic [ccr_pkg::PIXIDX_W-1:0]       pixel_col;
	logic [ccr_pkg::PIXIDX_W-1:0]       pixel_row;
	logic                               done;
	logic [ccr_pkg::BYTE_W-1:0]         pixel_value;
	logic                               outside_canvas;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [ccr_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [ccr_pkg::CFG_DIM_W-1:0]      cfg_data;

	// Typed-in expectation for the word on the bus
	bit                                 golden_use;
	logic [ccr_pkg::BYTE_W-1:0]         golden_value;
	logic                               golden_outside;

	// Canvas copy and register shadows
	logic [ccr_pkg::BYTE_W-1:0]         canvas_model [ccr_pkg::DEPTH];
	int                                 model_width;
	int                                 model_height;
	logic [ccr_pkg::BYTE_W-1:0]         model_bg;

	pixel_word_t                        expected_pixels [$];
	word_row_t                          directed_rows [$];
	int                                 error_count;
	int                                 n_checked;
	int                                 n_draw;
	int                                 n_read;
	int                                 n_clear;
	int                                 n_settings;
	int                                 burst_left;

	circle_canvas_rasterizer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.outline_only   (outline_only),
		.center_x       (center_x),
		.center_y       (center_y),
		.radius         (radius),
		.paint_byte     (paint_byte),
		.pixel_col      (pixel_col),
		.pixel_row      (pixel_row),
		.done           (done),
		.pixel_value    (pixel_value),
		.outside_canvas (outside_canvas),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int cols_in_use();
		return (model_width > ccr_pkg::MAX_COLUMNS) ? ccr_pkg::MAX_COLUMNS : model_width;
	endfunction

	function automatic int rows_in_use();
		return (model_height > ccr_pkg::MAX_ROWS) ? ccr_pkg::MAX_ROWS : model_height;
	endfunction

	// Paint every in-use pixel inside the disc, or inside the one-pixel ring
	function automatic void paint_circle(logic ring, logic signed [ccr_pkg::COORD_W-1:0] cx,
			logic signed [ccr_pkg::COORD_W-1:0] cy, logic [ccr_pkg::RADIUS_W-1:0] rad,
			logic [ccr_pkg::BYTE_W-1:0] paint);
		longint r, r2, m, m2, cxl, cyl, dx, dy, d2;
		int     w, h;
		bit     hit;
		w   = cols_in_use();
		h   = rows_in_use();
		cxl = longint'(cx);
		cyl = longint'(cy);
		r   = longint'(rad);
		r2  = r * r;
		m   = r - (longint'(1) << ccr_pkg::FRACTION_BITS);
		m2  = (m > 0) ? m * m : 0;
		for (int y = 0; y < h; y++) begin
			dy = cyl - (longint'(y) << ccr_pkg::FRACTION_BITS);
			for (int x = 0; x < w; x++) begin
				dx  = cxl - (longint'(x) << ccr_pkg::FRACTION_BITS);
				d2  = dx * dx + dy * dy;
				hit = (d2 <= r2);
				if (ring && m >= 0 && d2 <= m2)
					hit = 1'b0;
				if (hit)
					canvas_model[y * ccr_pkg::MAX_COLUMNS + x] = paint;
			end
		end
	endfunction

	// Work out the result word for the item on the bus and update the canvas copy
	function automatic pixel_word_t predict_pixel_word();
		pixel_word_t res;
		int          w, h;
		res = '0;
		w   = cols_in_use();
		h   = rows_in_use();
		if (action == ccr_pkg::ACT_DRAW) begin
			paint_circle(outline_only, center_x, center_y, radius, paint_byte);
		end else if (action == ccr_pkg::ACT_READ) begin
			if (int'(pixel_col) >= w || int'(pixel_row) >= h)
				res.outside = 1'b1;
			else
				res.value = canvas_model[int'(pixel_row) * ccr_pkg::MAX_COLUMNS +
					int'(pixel_col)];
		end else if (action == ccr_pkg::ACT_CLEAR) begin
			for (int y = 0; y < h; y++)
				for (int x = 0; x < w; x++)
					canvas_model[y * ccr_pkg::MAX_COLUMNS + x] = model_bg;
		end
		return res;
	endfunction

	// Check each result word against the oldest expectation, then queue the new item
	always @(posedge clk) begin : result_check
		pixel_word_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result value=%h outside=%b",
						$time, pixel_value, outside_canvas);
					error_count++;
				end else begin
					want = expected_pixels.pop_front();
					n_checked++;
					if (pixel_value !== want.value) begin
						$display("%0t: pixel_value expected %h actual %h",
							$time, want.value, pixel_value);
						error_count++;
					end
					if (outside_canvas !== want.outside) begin
						$display("%0t: outside_canvas expected %b actual %b",
							$time, want.outside, outside_canvas);
						error_count++;
					end
				end
			end
			if (start && !busy) begin
				want = predict_pixel_word();
				if (golden_use) begin
					want.value   = golden_value;
					want.outside = golden_outside;
				end
				expected_pixels.push_back(want);
				if (action == ccr_pkg::ACT_DRAW)
					n_draw++;
				else if (action == ccr_pkg::ACT_READ)
					n_read++;
				else if (action == ccr_pkg::ACT_CLEAR)
					n_clear++;
			end
		end
	end

	function automatic word_row_t mk_item(logic [1:0] act, logic outl,
			logic signed [ccr_pkg::COORD_W-1:0] cx, logic signed [ccr_pkg::COORD_W-1:0] cy,
			logic [ccr_pkg::RADIUS_W-1:0] rad, logic [ccr_pkg::BYTE_W-1:0] paint,
			logic [ccr_pkg::PIXIDX_W-1:0] pcol, logic [ccr_pkg::PIXIDX_W-1:0] prow);
		word_row_t r;
		r = '{kind: ROW_ITEM, act: act, outl: outl, cx: cx, cy: cy, rad: rad,
			paint: paint, pcol: pcol, prow: prow, reg_idx: '0, reg_data: '0,
			golden: 1'b0, gold_value: '0, gold_outside: 1'b0};
		return r;
	endfunction

	function automatic word_row_t with_golden(word_row_t r, logic [ccr_pkg::BYTE_W-1:0] v,
			logic o);
		r.golden       = 1'b1;
		r.gold_value   = v;
		r.gold_outside = o;
		return r;
	endfunction

	function automatic word_row_t mk_reg(logic [ccr_pkg::CFG_IDX_W-1:0] idx,
			logic [ccr_pkg::CFG_DIM_W-1:0] data);
		word_row_t r;
		r          = mk_item(ACT_UNUSED, 1'b0, '0, '0, '0, '0, '0, '0);
		r.kind     = ROW_CFG;
		r.reg_idx  = idx;
		r.reg_data = data;
		return r;
	endfunction

	// Draw a random item shaped by the current canvas size
	function automatic word_row_t random_word();
		word_row_t r;
		int        sel, w, h, span;
		w    = cols_in_use();
		h    = rows_in_use();
		span = ((w > h) ? w : h) / 2 + 2;
		sel  = $urandom_range(0, 99);
		r    = mk_item(ccr_pkg::ACT_DRAW, 1'($urandom_range(0, 1)),
			ccr_pkg::COORD_W'($urandom), ccr_pkg::COORD_W'($urandom),
			ccr_pkg::RADIUS_W'($urandom), ccr_pkg::BYTE_W'($urandom),
			ccr_pkg::PIXIDX_W'($urandom), ccr_pkg::PIXIDX_W'($urandom));
		if (sel < 36) begin
			r.cx  = ccr_pkg::COORD_W'(int'($urandom_range(0, (w + 4) * 256)) - 512);
			r.cy  = ccr_pkg::COORD_W'(int'($urandom_range(0, (h + 4) * 256)) - 512);
			r.rad = ccr_pkg::RADIUS_W'($urandom_range(0, span * 256));
		end else if (sel < 82) begin
			r.act = ccr_pkg::ACT_READ;
			if (w > 0 && h > 0 && $urandom_range(0, 99) < 85) begin
				r.pcol = ccr_pkg::PIXIDX_W'($urandom_range(0, w - 1));
				r.prow = ccr_pkg::PIXIDX_W'($urandom_range(0, h - 1));
			end
		end else if (sel < 92) begin
			r.act = ccr_pkg::ACT_CLEAR;
		end else if (sel < 96) begin
			r.act = ACT_UNUSED;
		end
		return r;
	endfunction

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (expected_pixels.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [ccr_pkg::CFG_IDX_W-1:0] idx,
			logic [ccr_pkg::CFG_DIM_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			ccr_pkg::REG_WIDTH:  model_width  = int'(data);
			ccr_pkg::REG_HEIGHT: model_height = int'(data);
			ccr_pkg::REG_BG:     model_bg     = data[ccr_pkg::BYTE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Hold the word on the bus until the block takes it
	task automatic drive_word(word_row_t r);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 15)) begin
				@(negedge clk);
				start = 1'b0;
			end
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 6);
		end
		burst_left--;
		@(negedge clk);
		action         = r.act;
		outline_only   = r.outl;
		center_x       = r.cx;
		center_y       = r.cy;
		radius         = r.rad;
		paint_byte     = r.paint;
		pixel_col      = r.pcol;
		pixel_row      = r.prow;
		golden_use     = r.golden;
		golden_value   = r.gold_value;
		golden_outside = r.gold_outside;
		start          = 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic run_row(word_row_t r);
		if (r.kind == ROW_CFG) begin
			drain();
			write_reg(r.reg_idx, r.reg_data);
		end else begin
			drive_word(r);
		end
	endtask

	initial begin
		word_row_t r;
		int        phase_len, mode, w, h, sent;
		arst_n         = 1'b0;
		start          = 1'b0;
		action         = ccr_pkg::ACT_DRAW;
		outline_only   = 1'b0;
		center_x       = '0;
		center_y       = '0;
		radius         = '0;
		paint_byte     = '0;
		pixel_col      = '0;
		pixel_row      = '0;
		cfg_valid      = 1'b0;
		cfg_index      = ccr_pkg::REG_WIDTH;
		cfg_data       = '0;
		golden_use     = 1'b0;
		golden_value   = '0;
		golden_outside = 1'b0;
		model_width    = 512;
		model_height   = 512;
		model_bg       = 8'd32;
		error_count    = 0;
		n_checked      = 0;
		n_draw         = 0;
		n_read         = 0;
		n_clear        = 0;
		n_settings     = 1;
		burst_left     = 0;

		// At reset size: clear the whole canvas so every pixel is defined
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, 0));
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0), 32, 0));
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 511, 511), 32, 0));
		// Small canvas, background with upper data bits set
		directed_rows.push_back(mk_reg(ccr_pkg::REG_WIDTH, 16));
		directed_rows.push_back(mk_reg(ccr_pkg::REG_HEIGHT, 12));
		directed_rows.push_back(mk_reg(ccr_pkg::REG_BG, 10'h3A5));
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, 0));
		directed_rows.push_back(mk_item(ccr_pkg::ACT_DRAW, 0, 7*256+128, 5*256+128, 4*256,
			8'h11, 0, 0));
		directed_rows.push_back(mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 7, 5));
		directed_rows.push_back(mk_item(ccr_pkg::ACT_DRAW, 1, 8*256, 6*256, 3*256+64,
			8'hEE, 0, 0));
		directed_rows.push_back(mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 8, 6));
		directed_rows.push_back(mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 11, 6));
		// Zero radius, filled and ring
		directed_rows.push_back(mk_item(ccr_pkg::ACT_DRAW, 0, 3*256, 3*256, 0, 8'hFF, 0, 0));
		directed_rows.push_back(mk_item(ccr_pkg::ACT_DRAW, 1, 2*256, 9*256, 0, 8'h00, 0, 0));
		directed_rows.push_back(mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 2, 9));
		// Extreme centers with the largest radius
		directed_rows.push_back(mk_item(ccr_pkg::ACT_DRAW, 0, 20'h80000, 20'h7FFFF,
			20'hFFFFF, 8'h5A, 0, 0));
		directed_rows.push_back(mk_item(ccr_pkg::ACT_DRAW, 1, 20'h7FFFF, 20'h7FFFF,
			20'hFFFFF, 8'hC3, 0, 0));
		directed_rows.push_back(mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 15, 11));
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 16, 0), 0, 1));
		directed_rows.push_back(with_golden(
			mk_item(ACT_UNUSED, 1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 8'hFF, 511, 511), 0, 0));
		// Empty canvas
		directed_rows.push_back(mk_reg(ccr_pkg::REG_WIDTH, 0));
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, 0));
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_DRAW, 0, 0, 0, 20'hFFFFF, 8'h77, 0, 0), 0, 0));
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0), 0, 1));
		// Oversized width saturates to the maximum
		directed_rows.push_back(mk_reg(ccr_pkg::REG_WIDTH, 10'h3FF));
		directed_rows.push_back(mk_reg(ccr_pkg::REG_HEIGHT, 2));
		directed_rows.push_back(mk_reg(ccr_pkg::REG_BG, 0));
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, 0));
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 511, 1), 0, 0));
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 2), 0, 1));
		// Unknown register index must be ignored; then a tall, narrow canvas
		directed_rows.push_back(mk_reg(REG_UNUSED, 10'h155));
		directed_rows.push_back(mk_reg(ccr_pkg::REG_WIDTH, 1));
		directed_rows.push_back(mk_reg(ccr_pkg::REG_HEIGHT, 10'h3FF));
		directed_rows.push_back(mk_item(ccr_pkg::ACT_DRAW, 0, 0, 300*256, 2*256, 8'hC3,
			0, 0));
		directed_rows.push_back(mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 300));
		directed_rows.push_back(with_golden(
			mk_item(ccr_pkg::ACT_READ, 0, 0, 0, 0, 0, 1, 0), 0, 1));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG &&
					directed_rows[i].reg_idx == ccr_pkg::REG_WIDTH)
				n_settings++;
			run_row(directed_rows[i]);
		end

		// Random phases, each on a fresh canvas setting
		sent = 0;
		while (sent < NUM_RANDOM) begin
			mode = $urandom_range(0, 9);
			case (mode)
				0: begin
					w = $urandom_range(512, 1023);
					h = $urandom_range(1, 3);
				end
				1: begin
					w = $urandom_range(1, 3);
					h = $urandom_range(512, 1023);
				end
				2: begin
					w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
					h = (w == 0) ? $urandom_range(1, 8) : 0;
				end
				default: begin
					w = $urandom_range(1, 24);
					h = $urandom_range(1, 24);
				end
			endcase
			drain();
			write_reg(ccr_pkg::REG_WIDTH, ccr_pkg::CFG_DIM_W'(w));
			write_reg(ccr_pkg::REG_HEIGHT, ccr_pkg::CFG_DIM_W'(h));
			write_reg(ccr_pkg::REG_BG, ccr_pkg::CFG_DIM_W'($urandom_range(0, 1023)));
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_UNUSED, ccr_pkg::CFG_DIM_W'($urandom_range(0, 1023)));
			n_settings++;
			phase_len = $urandom_range(6, 16);
			for (int k = 0; k < phase_len && sent < NUM_RANDOM; k++) begin
				r = random_word();
				drive_word(r);
				sent++;
			end
		end

		// Let the last results land
		drain();
		repeat (10) @(posedge clk);

		$display("Checked %0d result words: %0d draws, %0d reads, %0d clears.",
			n_checked, n_draw, n_read, n_clear);
		$display("Covered %0d canvas settings, from empty through saturated sizes.",
			n_settings);
		if (error_count == 0 && expected_pixels.size() == 0) begin
			$display("[circle_canvas_rasterizer] OK");
		end else begin
			if (expected_pixels.size() != 0)
				$display("%0t: %0d expected results never arrived",
					$time, expected_pixels.size());
			$display("[circle_canvas_rasterizer] ERROR");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#60_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, expected_pixels.size());
		$display("[circle_canvas_rasterizer] ERROR");
		$finish;
	end

endmodule
